// ===== rtl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants for the go-back-N sender window
// Sequence space, window size, field widths, action codes, the register
// map of the configuration port, and the structs passed between modules.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // Sequence space and send window
    localparam int SEQ_COUNT = 20;
    localparam int WINDOW    = 10;

    // Slot index width, set by the sequence space
    localparam int IDX_W  = $clog2(SEQ_COUNT);
    // Fixed field widths
    localparam int SEQ_W  = 5;
    localparam int CNT_W  = 16;
    localparam int TICK_W = 8;
    localparam int ACT_W  = 2;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register map, decoded from the word address bit
    localparam logic REG_TOTAL_PACKETS = 1'b0;
    localparam logic REG_TIMEOUT_LIMIT = 1'b1;

    // Register reset values
    localparam logic [CNT_W-1:0]  TOTAL_PACKETS_RST = 16'd4;
    localparam logic [TICK_W-1:0] TIMEOUT_LIMIT_RST = 8'd20;

    // Event codes
    typedef enum logic [ACT_W-1:0] {
        ACT_START = 2'd0,
        ACT_SEND  = 2'd1,
        ACT_ACK   = 2'd2,
        ACT_TICK  = 2'd3
    } t_action;

    // Configuration seen by the window logic
    typedef struct packed {
        logic [CNT_W-1:0]  total_packets;
        logic [TICK_W-1:0] timeout_limit;
    } t_cfg;

    // One result transaction
    typedef struct packed {
        logic              send_valid;
        logic [SEQ_W-1:0]  send_seq;
        logic [CNT_W-1:0]  packet_index;
        logic              timeout_fired;
        logic              done_res;
        logic [CNT_W-1:0]  acked_count;
    } t_result;

endpackage

// ===== rtl/go_back_n_sender_window_unit.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender_window_unit: go-back-N ARQ sender window
// Takes start, send, ack and idle-tick events and returns one result per
// event: the packet sent, rewind indication, completion and ack count.
//
//   channel  direction  handshake                payload
//   in       input      i_in_valid / o_in_stall  i_action, i_ack_seq
//   out      output     o_out_valid / i_out_stall o_send_valid .. o_acked_count
//   cfg      input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One transaction per cycle sustained while i_out_stall stays low; an accepted
// event passes the input register, then the result register, and o_out_valid
// rises when the event is written into the result register.
// The window update is a single pass of masks and counters between them.
// Synchronous active-low reset clears the window state and both stages.
// A stalled result holds; the input register keeps filling behind it and
// o_in_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Event channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [gbn_pkg::ACT_W-1:0]   i_action,
    input  logic [gbn_pkg::SEQ_W-1:0]   i_ack_seq,
    // Result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_send_valid,
    output logic [gbn_pkg::SEQ_W-1:0]   o_send_seq,
    output logic [gbn_pkg::CNT_W-1:0]   o_packet_index,
    output logic                        o_timeout_fired,
    output logic                        o_done_res,
    output logic [gbn_pkg::CNT_W-1:0]   o_acked_count,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gbn_pkg::ADDR_W-1:0]  paddr,
    input  logic [gbn_pkg::DATA_W-1:0]  pwdata,
    output logic [gbn_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    gbn_pkg::t_cfg               cfg;
    gbn_pkg::t_result            win_res;
    gbn_pkg::t_result            r_res;
    gbn_pkg::t_action            r_action;
    logic [gbn_pkg::SEQ_W-1:0]   r_ack_seq;
    logic                        r_in_valid;
    logic                        r_out_valid;
    logic                        in_accept;
    logic                        advance;

    // Configuration registers
    gbn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Window state and event logic
    gbn_win u_win (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_action  (r_action),
        .i_ack_seq (r_ack_seq),
        .i_cfg     (cfg),
        .o_res     (win_res)
    );

    // Handshake: the event moves on when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action  <= gbn_pkg::t_action'(i_action);
            r_ack_seq <= i_ack_seq;
        end
        if (advance) begin
            r_res <= win_res;
        end
    end

    // Result ports
    assign o_out_valid     = r_out_valid;
    assign o_send_valid    = r_res.send_valid;
    assign o_send_seq      = r_res.send_seq;
    assign o_packet_index  = r_res.packet_index;
    assign o_timeout_fired = r_res.timeout_fired;
    assign o_done_res      = r_res.done_res;
    assign o_acked_count   = r_res.acked_count;

    // An advancing event always lands in the result register
    a_adv_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced transaction lost");

    // Accepting over a held event requires it to move on in the same cycle
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && r_in_valid |-> advance)
        else $error("input register overwritten");

    // Idle sends carry a zero sequence and index
    a_idle_send_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.send_valid |-> (r_res.send_seq == '0)
            && (r_res.packet_index == '0))
        else $error("non-send result carries send fields");

endmodule

// ===== rtl/gbn_cfg.sv =====
// ----------------------------------------------------------------------------
// gbn_cfg: configuration registers
// APB-style register file holding the packet total and the timeout limit.
// Zero wait states; writes land on the access phase.
// ----------------------------------------------------------------------------
module gbn_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gbn_pkg::ADDR_W-1:0]   paddr,
    input  logic [gbn_pkg::DATA_W-1:0]   pwdata,
    output logic [gbn_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output gbn_pkg::t_cfg                o_cfg
);

    logic [gbn_pkg::CNT_W-1:0]  r_total_packets;
    logic [gbn_pkg::TICK_W-1:0] r_timeout_limit;
    logic                       wr_en;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[gbn_pkg::ADDR_W-1];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_packets <= gbn_pkg::TOTAL_PACKETS_RST;
            r_timeout_limit <= gbn_pkg::TIMEOUT_LIMIT_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                gbn_pkg::REG_TOTAL_PACKETS: begin
                    r_total_packets <= pwdata[gbn_pkg::CNT_W-1:0];
                end
                gbn_pkg::REG_TIMEOUT_LIMIT: begin
                    r_timeout_limit <= pwdata[gbn_pkg::TICK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            gbn_pkg::REG_TOTAL_PACKETS: begin
                prdata = gbn_pkg::DATA_W'(r_total_packets);
            end
            gbn_pkg::REG_TIMEOUT_LIMIT: begin
                prdata = gbn_pkg::DATA_W'(r_timeout_limit);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg.total_packets = r_total_packets;
    assign o_cfg.timeout_limit = r_timeout_limit;

endmodule

// ===== rtl/gbn_win.sv =====
// ----------------------------------------------------------------------------
// gbn_win: sender window state and event logic
// Holds the free-slot bitmap, pointers and counters. Computes one result
// and the next state from the registered event; state updates on i_step.
// ----------------------------------------------------------------------------
module gbn_win (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  gbn_pkg::t_action            i_action,
    input  logic [gbn_pkg::SEQ_W-1:0]   i_ack_seq,
    input  gbn_pkg::t_cfg               i_cfg,
    output gbn_pkg::t_result            o_res
);

    localparam int IW = gbn_pkg::IDX_W;
    localparam int CW = gbn_pkg::CNT_W;
    localparam int TW = gbn_pkg::TICK_W;
    localparam int SC = gbn_pkg::SEQ_COUNT;

    logic [SC-1:0] r_slot_free,   n_slot_free;
    logic [IW-1:0] r_next_seq,    n_next_seq;
    logic [IW-1:0] r_window_base, n_window_base;
    logic [CW-1:0] r_sent_count,  n_sent_count;
    logic [CW-1:0] r_ack_count,   n_ack_count;
    logic [TW-1:0] r_wait_ticks,  n_wait_ticks;

    logic [IW-1:0] outst;
    logic [IW-1:0] seq_inc;
    logic          send_ok;
    logic          fire;
    logic          ack_in_range;
    logic [IW-1:0] ack_idx;
    logic          ack_fwd;
    logic          ack_dup;
    logic [IW:0]   ack_n;
    logic [CW:0]   ack_sum;
    logic [CW-1:0] ack_sat;
    logic [IW-1:0] base_fwd;
    logic [SC-1:0] ack_mask;
    logic [SC-1:0] rewind_mask;
    logic [CW-1:0] sent_back;

    // Outstanding packets, modulo the sequence space
    assign outst = (r_next_seq >= r_window_base) ? IW'(r_next_seq - r_window_base)
                 : IW'(r_next_seq + IW'(SC) - r_window_base);

    assign seq_inc = (r_next_seq == IW'(SC - 1)) ? '0 : IW'(r_next_seq + 1'b1);

    // Send and timeout qualifiers
    assign send_ok = (32'(outst) < 32'(gbn_pkg::WINDOW)) && r_slot_free[r_next_seq]
                  && (r_sent_count < i_cfg.total_packets);
    assign fire    = (r_wait_ticks >= i_cfg.timeout_limit);

    // Cumulative ack decode
    assign ack_in_range = (i_ack_seq != '0) && (32'(i_ack_seq) <= 32'(SC));
    assign ack_idx      = IW'(i_ack_seq - 1'b1);
    assign ack_fwd      = (r_window_base <= ack_idx);
    assign ack_dup      = ({1'b0, r_window_base} == ({1'b0, ack_idx} + 1'b1));
    assign ack_n        = ack_fwd ? (IW + 1)'({1'b0, ack_idx} - {1'b0, r_window_base} + 1'b1)
                        : (IW + 1)'((IW + 1)'(SC) - {1'b0, r_window_base}
                                    + {1'b0, ack_idx} + 1'b1);
    assign ack_sum      = {1'b0, r_ack_count} + (CW + 1)'(ack_n);
    assign ack_sat      = ack_sum[CW] ? '1 : ack_sum[CW-1:0];
    assign base_fwd     = (ack_idx == IW'(SC - 1)) ? '0 : IW'(ack_idx + 1'b1);

    // Rewind drops outstanding packets from the sent count, floor at zero
    assign sent_back = (r_sent_count > CW'(outst)) ? CW'(r_sent_count - CW'(outst)) : '0;

    // Per-slot masks for ack release and rewind release
    always_comb begin
        logic [IW-1:0] jj;
        logic [IW-1:0] offs;
        for (int j = 0; j < SC; j++) begin
            jj   = IW'(j);
            offs = (jj >= r_window_base) ? IW'(jj - r_window_base)
                 : IW'(jj + IW'(SC) - r_window_base);
            if (ack_fwd) begin
                ack_mask[j] = (jj >= r_window_base) && (jj <= ack_idx);
            end else begin
                ack_mask[j] = (jj >= r_window_base) || (jj <= ack_idx);
            end
            rewind_mask[j] = (32'(offs) < 32'(gbn_pkg::WINDOW));
        end
    end

    // Next state and result
    always_comb begin
        n_slot_free   = r_slot_free;
        n_next_seq    = r_next_seq;
        n_window_base = r_window_base;
        n_sent_count  = r_sent_count;
        n_ack_count   = r_ack_count;
        n_wait_ticks  = r_wait_ticks;
        o_res         = '0;

        unique case (i_action)
            gbn_pkg::ACT_START: begin
                n_slot_free   = '1;
                n_next_seq    = '0;
                n_window_base = '0;
                n_sent_count  = '0;
                n_ack_count   = '0;
                n_wait_ticks  = '0;
            end
            gbn_pkg::ACT_SEND: begin
                if (send_ok) begin
                    o_res.send_valid   = 1'b1;
                    o_res.send_seq     = gbn_pkg::SEQ_W'(r_next_seq) + 1'b1;
                    o_res.packet_index = r_sent_count;
                    n_slot_free[r_next_seq] = 1'b0;
                    n_next_seq   = seq_inc;
                    n_sent_count = CW'(r_sent_count + 1'b1);
                end
            end
            gbn_pkg::ACT_ACK: begin
                n_wait_ticks = '0;
                if (ack_in_range && (ack_fwd || !ack_dup)) begin
                    n_slot_free   = r_slot_free | ack_mask;
                    n_ack_count   = ack_sat;
                    n_window_base = ack_fwd ? base_fwd : IW'(ack_idx + 1'b1);
                end
            end
            gbn_pkg::ACT_TICK: begin
                if (fire) begin
                    o_res.timeout_fired = 1'b1;
                    n_slot_free  = r_slot_free | rewind_mask;
                    n_sent_count = sent_back;
                    n_next_seq   = r_window_base;
                    n_wait_ticks = '0;
                end else begin
                    n_wait_ticks = TW'(r_wait_ticks + 1'b1);
                end
            end
            default: begin
            end
        endcase

        o_res.done_res    = (n_ack_count == i_cfg.total_packets);
        o_res.acked_count = n_ack_count;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_free   <= '1;
            r_next_seq    <= '0;
            r_window_base <= '0;
            r_sent_count  <= '0;
            r_ack_count   <= '0;
            r_wait_ticks  <= '0;
        end else if (i_step) begin
            r_slot_free   <= n_slot_free;
            r_next_seq    <= n_next_seq;
            r_window_base <= n_window_base;
            r_sent_count  <= n_sent_count;
            r_ack_count   <= n_ack_count;
            r_wait_ticks  <= n_wait_ticks;
        end
    end

    // Pointers stay inside the sequence space
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_next_seq) < 32'(SC)) && (32'(r_window_base) < 32'(SC)))
        else $error("window pointer out of sequence space");

    // A sent packet bumps the sent count by one
    a_send_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.send_valid |=> r_sent_count == CW'($past(r_sent_count) + 1'b1))
        else $error("sent count did not advance on send");

    // Only a start can lower the ack count
    a_ack_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_action != gbn_pkg::ACT_START) |=> r_ack_count >= $past(r_ack_count))
        else $error("ack count decreased");

    // A sent slot is marked busy afterwards
    a_slot_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.send_valid |=> !r_slot_free[$past(r_next_seq)])
        else $error("sent slot still free");

endmodule
